>>> sv/life_grid_generation_engine_macros.svh
// ---------------------------------------------------------------------------
// Life grid generation engine: assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_ENGINE_MACROS_SVH
`define LIFE_GRID_GENERATION_ENGINE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define LGGE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgge assertion failed");

// Next-cycle implication
`define LGGE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgge assertion failed");

`else

`define LGGE_ASSERT_NOW(label, clk, rst_n, ante, cons)

`define LGGE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/lgge_pkg.sv
// ---------------------------------------------------------------------------
// Life grid generation engine package
// Field widths, command codes, rule constants and controller states.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lgge_pkg;

    // Transaction field widths
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 4;
    localparam int CELLS_W = 16;

    // B3/S23 neighbor counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Command codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD = 2'd0,
        MODE_STEP = 2'd1,
        MODE_SHOW = 2'd2
    } mode_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_RUN
    } state_t;

endpackage

>>> sv/lgge_in_if.sv
// ---------------------------------------------------------------------------
// Life grid input channel
// Valid/ready channel carrying one command transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lgge_in_if;

    logic                         valid;
    logic                         ready;
    logic [lgge_pkg::MODE_W-1:0]  mode;
    logic [lgge_pkg::INDEX_W-1:0] row_index;
    logic [lgge_pkg::CELLS_W-1:0] row_cells;

    modport source (output valid, output mode, output row_index, output row_cells,
                    input ready);
    modport sink   (input valid, input mode, input row_index, input row_cells,
                    output ready);

endinterface

>>> sv/lgge_out_if.sv
// ---------------------------------------------------------------------------
// Life grid output channel
// Valid/ready channel carrying one emitted grid row per transaction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lgge_out_if;

    logic                         valid;
    logic                         ready;
    logic [lgge_pkg::INDEX_W-1:0] out_row_index;
    logic [lgge_pkg::CELLS_W-1:0] out_row_cells;
    logic                         last_row;

    modport source (output valid, output out_row_index, output out_row_cells,
                    output last_row, input ready);
    modport sink   (input valid, input out_row_index, input out_row_cells,
                    input last_row, output ready);

endinterface

>>> sv/lgge_cell_lane.sv
// ---------------------------------------------------------------------------
// Life grid cell lane
// Applies the B3/S23 rule to one cell from its 3x3 neighborhood.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgge_cell_lane (
    input  logic [2:0] up,
    input  logic [2:0] mid,
    input  logic [2:0] down,
    output logic       alive
);

    logic [3:0] count;

    // Eight-neighbor population, center excluded
    assign count = 4'(up[0]) + 4'(up[1]) + 4'(up[2])
                 + 4'(mid[0]) + 4'(mid[2])
                 + 4'(down[0]) + 4'(down[1]) + 4'(down[2]);

    // Birth on three, survival on two or three
    assign alive = (count == lgge_pkg::BIRTH_COUNT)
                 || ((count == lgge_pkg::SURVIVE_COUNT) && mid[1]);

endmodule

>>> sv/lgge_row_unit.sv
// ---------------------------------------------------------------------------
// Life grid row unit
// One cell lane per column; lane outputs are merged into the new row.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lgge_row_unit #(
    parameter int GRID_SIZE = 16
) (
    input  logic [GRID_SIZE-1:0] up_row,
    input  logic [GRID_SIZE-1:0] mid_row,
    input  logic [GRID_SIZE-1:0] down_row,
    output logic [GRID_SIZE-1:0] next_row
);

    // Dead border on both sides: cells beyond the edges never count
    logic [GRID_SIZE+1:0] up_pad;
    logic [GRID_SIZE+1:0] mid_pad;
    logic [GRID_SIZE+1:0] down_pad;

    assign up_pad   = {1'b0, up_row, 1'b0};
    assign mid_pad  = {1'b0, mid_row, 1'b0};
    assign down_pad = {1'b0, down_row, 1'b0};

    // Column lanes, merged bit by bit into the output row
    for (genvar c = 0; c < GRID_SIZE; c++) begin : g_lane
        lgge_cell_lane u_lane (
            .up    (up_pad[c+2:c]),
            .mid   (mid_pad[c+2:c]),
            .down  (down_pad[c+2:c]),
            .alive (next_row[c])
        );
    end

endmodule

>>> sv/life_grid_generation_engine.sv
// Load (mode 0): no result. Emit (mode 1 or 2): accepted only in idle, then a prime state
// fills the row window, then one row per cycle while the output is not stalled; the first row
// passes the read register, the window registers and the output register before it is valid.
// The grid memory has a single read port, which feeds the three-row sliding window.
// Reset is asynchronous; per-row valid bits make the whole grid read dead at once,
// so the block takes commands as soon as reset is released.
// ---------------------------------------------------------------------------
// Life grid generation engine
// Bounded B3/S23 grid: row loads, in-place generation sweep and row readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "life_grid_generation_engine_macros.svh"

module life_grid_generation_engine #(
    parameter int GRID_SIZE = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    lgge_in_if.sink    in_ch,
    lgge_out_if.source out_ch
);

    localparam int ROW_W    = $clog2(GRID_SIZE);
    localparam int IDX_WIDE = ((ROW_W > lgge_pkg::INDEX_W) ? ROW_W : lgge_pkg::INDEX_W) + 1;
    localparam int CELL_WIDE = (GRID_SIZE > lgge_pkg::CELLS_W) ? GRID_SIZE : lgge_pkg::CELLS_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_SIZE - 1);
    localparam logic [ROW_W:0]   RD_LIMIT = (ROW_W + 1)'(GRID_SIZE);

    // Control state
    lgge_pkg::state_t state_reg, state_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [ROW_W:0]   rd_cnt_reg, rd_cnt_next;
    logic             step_mode_reg, step_mode_next;

    // Row window: above and center rows; the row below sits in the read register
    logic [GRID_SIZE-1:0] up_reg, up_next;
    logic [GRID_SIZE-1:0] mid_reg, mid_next;

    // Grid memory and its read register
    logic [GRID_SIZE-1:0] grid_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] row_valid_reg;
    logic [GRID_SIZE-1:0] rd_raw_reg;
    logic                 rd_ok_reg;

    // Output register
    logic                         out_valid_reg;
    logic [lgge_pkg::INDEX_W-1:0] out_idx_reg;
    logic [lgge_pkg::CELLS_W-1:0] out_cells_reg;
    logic                         out_last_reg;

    logic                   in_fire;
    lgge_pkg::mode_t        in_mode;
    logic [IDX_WIDE-1:0]    load_idx_wide;
    logic                   load_in_range;
    logic [ROW_W-1:0]       load_addr;
    logic [CELL_WIDE-1:0]   load_cells_wide;
    logic [GRID_SIZE-1:0]   load_row;
    logic                   load_we;
    logic                   rd_load;
    logic [ROW_W:0]         rd_addr_wide;
    logic [ROW_W-1:0]       rd_addr;
    logic                   rd_hit;
    logic                   adv;
    logic                   out_free;
    logic [GRID_SIZE-1:0]   below_row;
    logic [GRID_SIZE-1:0]   next_row;
    logic                   mem_we;
    logic [ROW_W-1:0]       wr_addr;
    logic [GRID_SIZE-1:0]   wr_data;
    logic [GRID_SIZE-1:0]   emit_row;
    logic [CELL_WIDE-1:0]   emit_cells_wide;
    logic [IDX_WIDE-1:0]    emit_idx_wide;

    // Input decode
    assign in_ch.ready     = (state_reg == lgge_pkg::ST_IDLE);
    assign in_fire         = in_ch.valid & in_ch.ready;
    assign in_mode         = lgge_pkg::mode_t'(in_ch.mode);
    assign load_idx_wide   = IDX_WIDE'(in_ch.row_index);
    assign load_in_range   = (load_idx_wide < IDX_WIDE'(GRID_SIZE));
    assign load_addr       = load_idx_wide[ROW_W-1:0];
    assign load_cells_wide = CELL_WIDE'(in_ch.row_cells);
    assign load_row        = load_cells_wide[GRID_SIZE-1:0];

    // Read address: row 0 on command accept, else the prefetch counter
    assign rd_addr_wide = (state_reg == lgge_pkg::ST_IDLE) ? '0 : rd_cnt_reg;
    assign rd_hit       = (rd_addr_wide < RD_LIMIT);
    assign rd_addr      = rd_addr_wide[ROW_W-1:0];
    assign below_row    = rd_ok_reg ? rd_raw_reg : '0;

    assign out_free = ~out_valid_reg | out_ch.ready;

    // Column lanes
    lgge_row_unit #(
        .GRID_SIZE (GRID_SIZE)
    ) u_row_unit (
        .up_row   (up_reg),
        .mid_row  (mid_reg),
        .down_row (below_row),
        .next_row (next_row)
    );

    // Controller next state
    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        rd_cnt_next    = rd_cnt_reg;
        step_mode_next = step_mode_reg;
        up_next        = up_reg;
        mid_next       = mid_reg;
        load_we        = 1'b0;
        rd_load        = 1'b0;
        adv            = 1'b0;
        unique case (state_reg)
            lgge_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_mode) inside
                        lgge_pkg::MODE_LOAD:
                        begin
                            load_we = load_in_range;
                        end
                        lgge_pkg::MODE_STEP, lgge_pkg::MODE_SHOW:
                        begin
                            state_next     = lgge_pkg::ST_PRIME;
                            rd_load        = 1'b1;
                            rd_cnt_next    = (ROW_W + 1)'(1);
                            row_cnt_next   = '0;
                            up_next        = '0;
                            step_mode_next = (in_mode == lgge_pkg::MODE_STEP);
                        end
                        default: ;
                    endcase
                end
            end
            lgge_pkg::ST_PRIME:
            begin
                state_next  = lgge_pkg::ST_RUN;
                rd_load     = 1'b1;
                rd_cnt_next = rd_cnt_reg + (ROW_W + 1)'(1);
                mid_next    = below_row;
            end
            lgge_pkg::ST_RUN:
            begin
                if (out_free)
                begin
                    adv         = 1'b1;
                    rd_load     = 1'b1;
                    rd_cnt_next = rd_cnt_reg + (ROW_W + 1)'(1);
                    up_next     = mid_reg;
                    mid_next    = below_row;
                    if (row_cnt_reg == LAST_ROW)
                    begin
                        state_next   = lgge_pkg::ST_IDLE;
                        row_cnt_next = '0;
                    end
                    else
                    begin
                        row_cnt_next = row_cnt_reg + ROW_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = lgge_pkg::ST_IDLE;
            end
        endcase
    end

    // Controller registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lgge_pkg::ST_IDLE;
            row_cnt_reg   <= '0;
            rd_cnt_reg    <= '0;
            step_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            step_mode_reg <= step_mode_next;
        end
    end

    // Window registers
    always_ff @(posedge clk)
    begin
        up_reg  <= up_next;
        mid_reg <= mid_next;
    end

    // Memory write: row load, or in-place write-back of the new row
    assign mem_we  = load_we | (adv & step_mode_reg);
    assign wr_addr = load_we ? load_addr : row_cnt_reg;
    assign wr_data = load_we ? load_row : next_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (rd_load)
        begin
            rd_raw_reg <= grid_mem[rd_addr];
        end
    end

    // Row valid bits; an unwritten row reads as dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_load)
            begin
                rd_ok_reg <= rd_hit & row_valid_reg[rd_addr];
            end
        end
    end

    // Output payload
    assign emit_row        = step_mode_reg ? next_row : mid_reg;
    assign emit_cells_wide = CELL_WIDE'(emit_row);
    assign emit_idx_wide   = IDX_WIDE'(row_cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_idx_reg   <= emit_idx_wide[lgge_pkg::INDEX_W-1:0];
            out_cells_reg <= emit_cells_wide[lgge_pkg::CELLS_W-1:0];
            out_last_reg  <= (row_cnt_reg == LAST_ROW);
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_row_index = out_idx_reg;
    assign out_ch.out_row_cells = out_cells_reg;
    assign out_ch.last_row      = out_last_reg;

    // Checks
    `LGGE_ASSERT_NEXT(a_prime_one_cycle, clk, rst_n, state_reg == lgge_pkg::ST_PRIME, state_reg == lgge_pkg::ST_RUN)
    `LGGE_ASSERT_NEXT(a_stall_holds_row, clk, rst_n, (state_reg == lgge_pkg::ST_RUN) && out_valid_reg && !out_ch.ready, $stable(row_cnt_reg))
    `LGGE_ASSERT_NEXT(a_last_row_ends, clk, rst_n, adv && (row_cnt_reg == LAST_ROW), (state_reg == lgge_pkg::ST_IDLE) && out_last_reg)
    `LGGE_ASSERT_NOW(a_below_edge_dead, clk, rst_n, (state_reg == lgge_pkg::ST_RUN) && (row_cnt_reg == LAST_ROW), !rd_ok_reg)

endmodule

>>> sim/life_grid_generation_engine_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Life grid generation engine testbench
// Loads rows, advances generations and reads the grid back through the two
// valid/ready channels. A local B3/S23 model with dead edges predicts each
// emitted row, and the monitor checks the rows field by field, in order.
// ---------------------------------------------------------------------------

module life_grid_generation_engine_tb;

    localparam int GRID          = 16;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_AT_ROW   = 200;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_ITEMS  = 110;

    // Mode code the block has no use for
    localparam logic [lgge_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Columns that exist in the grid
    localparam logic [lgge_pkg::CELLS_W-1:0] ROW_MASK =
        {lgge_pkg::CELLS_W{1'b1}} >> (lgge_pkg::CELLS_W - GRID);

    typedef struct {
        logic [lgge_pkg::MODE_W-1:0]  mode;
        logic [lgge_pkg::INDEX_W-1:0] row_index;
        logic [lgge_pkg::CELLS_W-1:0] row_cells;
        int unsigned                  gap;
    } command_t;

    typedef struct {
        logic [lgge_pkg::INDEX_W-1:0] row_index;
        logic [lgge_pkg::CELLS_W-1:0] row_cells;
        logic                         last_row;
    } grid_row_t;

    logic clk = 1'b0;
    logic rst_n;

    lgge_in_if  in_ch ();
    lgge_out_if out_ch ();

    life_grid_generation_engine #(
        .GRID_SIZE(GRID)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    always #5 clk = ~clk;

    // Predicted grid and the rows still owed by the block
    logic [lgge_pkg::CELLS_W-1:0] life_rows [GRID];
    command_t                     pending_commands [$];
    grid_row_t                    expected_rows [$];

    int          error_count = 0;
    int unsigned cycle_count = 0;

    // Live neighbors of one cell; cells past any edge are dead
    function automatic int unsigned live_neighbors(int r, int c);
        int unsigned n;
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID &&
                    c + dc >= 0 && c + dc < GRID)
                    n += life_rows[r + dr][c + dc];
        return n;
    endfunction

    // One B3/S23 generation over the whole grid
    function automatic void advance_generation();
        logic [lgge_pkg::CELLS_W-1:0] fresh [GRID];
        int unsigned n;
        for (int r = 0; r < GRID; r++)
        begin
            fresh[r] = '0;
            for (int c = 0; c < GRID; c++)
            begin
                n = live_neighbors(r, c);
                if (n == lgge_pkg::BIRTH_COUNT ||
                    (n == lgge_pkg::SURVIVE_COUNT && life_rows[r][c]))
                    fresh[r][c] = 1'b1;
            end
        end
        for (int r = 0; r < GRID; r++)
            life_rows[r] = fresh[r];
    endfunction

    function automatic void queue_grid_rows();
        grid_row_t row;
        for (int r = 0; r < GRID; r++)
        begin
            row.row_index = lgge_pkg::INDEX_W'(r);
            row.row_cells = life_rows[r];
            row.last_row  = (r == GRID - 1);
            expected_rows.push_back(row);
        end
    endfunction

    function automatic void apply_command(command_t cmd);
        case (cmd.mode)
            lgge_pkg::MODE_LOAD:
                if (cmd.row_index < GRID)
                    life_rows[cmd.row_index] = cmd.row_cells & ROW_MASK;
            lgge_pkg::MODE_STEP:
            begin
                advance_generation();
                queue_grid_rows();
            end
            lgge_pkg::MODE_SHOW:
                queue_grid_rows();
            default:
                ;
        endcase
    endfunction

    function automatic void add_command(logic [lgge_pkg::MODE_W-1:0]  mode,
                                        logic [lgge_pkg::INDEX_W-1:0] idx,
                                        logic [lgge_pkg::CELLS_W-1:0] cells,
                                        int unsigned                  gap);
        command_t cmd;
        cmd.mode      = mode;
        cmd.row_index = idx;
        cmd.row_cells = cells;
        cmd.gap       = gap;
        pending_commands.push_back(cmd);
    endfunction

    function automatic logic [lgge_pkg::CELLS_W-1:0] random_cells();
        case ($urandom_range(0, 3))
            0:       return lgge_pkg::CELLS_W'($urandom);
            1:       return lgge_pkg::CELLS_W'($urandom & $urandom);
            2:       return lgge_pkg::CELLS_W'($urandom & $urandom & $urandom);
            default: return lgge_pkg::CELLS_W'($urandom | $urandom);
        endcase
    endfunction

    // Driver: offers queued commands after each one's idle gap
    logic        offering   = 1'b0;
    logic        gap_loaded = 1'b0;
    int unsigned send_wait  = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                apply_command(pending_commands.pop_front());
                offering   = 1'b0;
                gap_loaded = 1'b0;
            end
            if (!offering && pending_commands.size() != 0)
            begin
                if (!gap_loaded)
                begin
                    send_wait  = pending_commands[0].gap;
                    gap_loaded = 1'b1;
                end
                if (send_wait != 0)
                    send_wait--;
                else
                begin
                    in_ch.mode      <= pending_commands[0].mode;
                    in_ch.row_index <= pending_commands[0].row_index;
                    in_ch.row_cells <= pending_commands[0].row_cells;
                    offering = 1'b1;
                end
            end
            in_ch.valid <= offering;
        end
    end

    // Monitor: checks each row transaction, stalls at random, once for a long stretch
    int unsigned rows_seen = 0;
    int unsigned rx_wait   = 0;

    always @(posedge clk)
    begin
        grid_row_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_rows.size() == 0)
                begin
                    $error("unexpected row transaction: out_row_index %0d out_row_cells %h",
                           out_ch.out_row_index, out_ch.out_row_cells);
                    error_count++;
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (out_ch.out_row_index !== want.row_index)
                    begin
                        $error("out_row_index: expected %0d, actual %0d",
                               want.row_index, out_ch.out_row_index);
                        error_count++;
                    end
                    if (out_ch.out_row_cells !== want.row_cells)
                    begin
                        $error("out_row_cells: expected %h, actual %h",
                               want.row_cells, out_ch.out_row_cells);
                        error_count++;
                    end
                    if (out_ch.last_row !== want.last_row)
                    begin
                        $error("last_row: expected %0b, actual %0b",
                               want.last_row, out_ch.last_row);
                        error_count++;
                    end
                end
                rows_seen++;
                // every third stretch of 64 rows runs without stalls
                rx_wait = ((rows_seen / 64) % 3 == 2) ? 0 : $urandom_range(0, 4);
                if (rows_seen == HOLD_AT_ROW)
                    rx_wait = HOLD_CYCLES;
            end
            if (rx_wait != 0)
            begin
                rx_wait--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned made;
        int unsigned loads;
        int unsigned emits;
        bit          quiet;

        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.mode      = lgge_pkg::MODE_LOAD;
        in_ch.row_index = '0;
        in_ch.row_cells = '0;
        out_ch.ready    = 1'b0;
        for (int r = 0; r < GRID; r++)
            life_rows[r] = '0;

        // Directed: empty grid, full edge rows, ignored fields, unused mode, glider
        add_command(lgge_pkg::MODE_SHOW, 4'h0, 16'h0000, 0);
        add_command(lgge_pkg::MODE_STEP, 4'h0, 16'h0000, 1);
        add_command(lgge_pkg::MODE_LOAD, 4'h0, 16'hFFFF, 0);
        add_command(lgge_pkg::MODE_LOAD, 4'hF, 16'hFFFF, 2);
        add_command(lgge_pkg::MODE_LOAD, 4'h7, 16'h8001, 0);
        add_command(lgge_pkg::MODE_LOAD, 4'h8, 16'h8001, 0);
        add_command(lgge_pkg::MODE_SHOW, 4'hF, 16'hFFFF, 3);
        add_command(lgge_pkg::MODE_STEP, 4'hF, 16'hFFFF, 0);
        add_command(lgge_pkg::MODE_STEP, 4'h0, 16'h0000, 4);
        add_command(MODE_UNUSED, 4'h3, 16'hA5A5, 0);
        add_command(MODE_UNUSED, 4'hF, 16'hFFFF, 0);
        add_command(lgge_pkg::MODE_SHOW, 4'h5, 16'h5A5A, 1);
        add_command(lgge_pkg::MODE_LOAD, 4'h0, 16'h0000, 0);
        add_command(lgge_pkg::MODE_LOAD, 4'hF, 16'h0000, 0);
        add_command(lgge_pkg::MODE_LOAD, 4'h1, 16'h4000, 0);
        add_command(lgge_pkg::MODE_LOAD, 4'h2, 16'h8000, 0);
        add_command(lgge_pkg::MODE_LOAD, 4'h3, 16'hE000, 2);
        add_command(lgge_pkg::MODE_STEP, 4'h0, 16'h0000, 0);
        add_command(lgge_pkg::MODE_STEP, 4'h0, 16'h0000, 0);
        add_command(lgge_pkg::MODE_STEP, 4'h0, 16'h0000, 1);
        add_command(lgge_pkg::MODE_LOAD, 4'hE, 16'h0007, 0);
        add_command(lgge_pkg::MODE_STEP, 4'hA, 16'h0001, 0);
        add_command(lgge_pkg::MODE_SHOW, 4'h0, 16'h0000, 0);

        // Random: bursts of row loads followed by generations or readouts
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            loads = $urandom_range(0, 6);
            emits = $urandom_range(1, 3);
            for (int i = 0; i < loads; i++)
            begin
                add_command(lgge_pkg::MODE_LOAD, lgge_pkg::INDEX_W'($urandom),
                            random_cells(), quiet ? 0 : $urandom_range(0, 4));
                made++;
            end
            if ($urandom_range(0, 7) == 0)
                add_command(MODE_UNUSED, lgge_pkg::INDEX_W'($urandom),
                            lgge_pkg::CELLS_W'($urandom),
                            quiet ? 0 : $urandom_range(0, 4));
            for (int i = 0; i < emits; i++)
            begin
                add_command(($urandom_range(0, 3) == 0) ? lgge_pkg::MODE_SHOW
                                                        : lgge_pkg::MODE_STEP,
                            lgge_pkg::INDEX_W'($urandom), lgge_pkg::CELLS_W'($urandom),
                            quiet ? 0 : $urandom_range(0, 4));
                made++;
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Drain, then give the block time to show any stray row
        while (pending_commands.size() != 0 || in_ch.valid || expected_rows.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_rows.size() != 0)
        begin
            $error("rows still expected at end: %0d", expected_rows.size());
            error_count++;
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
